// ----- hw/rtl/ptb_pkg.sv -----
`default_nettype none

package ptb_pkg;

  // Physical timer slots and field widths.
  localparam int SLOTS    = 4;
  localparam int PERIOD_W = 24;
  localparam int COUNT_W  = 25;
  localparam int MS_W     = 16;
  localparam int MASK_W   = 4;
  localparam int ADDR_W   = 5;
  localparam int DATA_W   = 32;

  // Register indexes on the configuration port (byte address is four times the index).
  typedef enum logic [2:0] {
    REG_PERIOD_A   = 3'd0,
    REG_PERIOD_B   = 3'd1,
    REG_PERIOD_C   = 3'd2,
    REG_PERIOD_D   = 3'd3,
    REG_IRQ_MASK   = 3'd4,
    REG_ENABLE_MASK = 3'd5
  } reg_idx_t;

  // Item modes.
  localparam logic MODE_TICK = 1'b0;
  localparam logic MODE_POLL = 1'b1;

  // Sequencer states.
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_WALK,
    ST_DONE
  } state_t;

  typedef struct packed {
    logic            mode;
    logic [MS_W-1:0] elapsed_ms;
  } in_item_t;

  typedef struct packed {
    logic [MASK_W-1:0] fire_mask;
    logic [MASK_W-1:0] run_mask;
  } out_item_t;

  // Configuration as seen by the sequencer.
  typedef struct packed {
    logic [SLOTS-1:0][PERIOD_W-1:0] period;
    logic [MASK_W-1:0]              irq_mask;
    logic [MASK_W-1:0]              en_mask;
  } cfg_t;

endpackage

`default_nettype wire

// ----- hw/rtl/ptb_ram.sv -----
`default_nettype none

module ptb_ram #(
  parameter int WIDTH = 25,
  parameter int DEPTH = 4,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    waddr,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic [AW-1:0]    raddr,
  output logic      [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  // Single write port and a registered read port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    rdata_r <= mem_r[raddr];
  end

  assign rdata = rdata_r;

endmodule

`default_nettype wire

// ----- hw/rtl/ptb_cfg.sv -----
`default_nettype none

module ptb_cfg
  import ptb_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              psel,
  input  wire logic              penable,
  input  wire logic              pwrite,
  input  wire logic [ADDR_W-1:0] paddr,
  input  wire logic [DATA_W-1:0] pwdata,
  output logic      [DATA_W-1:0] prdata,
  output logic                   pready,
  output cfg_t                   cfg
);

  logic [SLOTS-1:0][PERIOD_W-1:0] period_r, period_nxt;
  logic [MASK_W-1:0]              irq_r, irq_nxt;
  logic [MASK_W-1:0]              en_r, en_nxt;
  reg_idx_t                       idx;
  logic                           wr_en;

  assign idx    = reg_idx_t'(paddr[ADDR_W-1:2]);
  assign wr_en  = psel && penable && pwrite;
  assign pready = 1'b1;

  // Register write decode; indexes past the last register are ignored.
  always_comb begin
    period_nxt = period_r;
    irq_nxt    = irq_r;
    en_nxt     = en_r;
    if (wr_en) begin
      unique case (idx)
        REG_PERIOD_A:    period_nxt[0] = pwdata[PERIOD_W-1:0];
        REG_PERIOD_B:    period_nxt[1] = pwdata[PERIOD_W-1:0];
        REG_PERIOD_C:    period_nxt[2] = pwdata[PERIOD_W-1:0];
        REG_PERIOD_D:    period_nxt[3] = pwdata[PERIOD_W-1:0];
        REG_IRQ_MASK:    irq_nxt       = pwdata[MASK_W-1:0];
        REG_ENABLE_MASK: en_nxt        = pwdata[MASK_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      period_r <= '0;
      irq_r    <= '0;
      en_r     <= '0;
    end else begin
      period_r <= period_nxt;
      irq_r    <= irq_nxt;
      en_r     <= en_nxt;
    end
  end

  // Read decode.
  always_comb begin
    unique case (idx)
      REG_PERIOD_A:    prdata = {{(DATA_W-PERIOD_W){1'b0}}, period_r[0]};
      REG_PERIOD_B:    prdata = {{(DATA_W-PERIOD_W){1'b0}}, period_r[1]};
      REG_PERIOD_C:    prdata = {{(DATA_W-PERIOD_W){1'b0}}, period_r[2]};
      REG_PERIOD_D:    prdata = {{(DATA_W-PERIOD_W){1'b0}}, period_r[3]};
      REG_IRQ_MASK:    prdata = {{(DATA_W-MASK_W){1'b0}}, irq_r};
      REG_ENABLE_MASK: prdata = {{(DATA_W-MASK_W){1'b0}}, en_r};
      default:         prdata = '0;
    endcase
  end

  assign cfg.period   = period_r;
  assign cfg.irq_mask = irq_r;
  assign cfg.en_mask  = en_r;

endmodule

`default_nettype wire

// ----- hw/rtl/ptb_seq.sv -----
`default_nettype none

module ptb_seq
  import ptb_pkg::*;
#(
  parameter int TIMERS = 4,
  localparam int IDX_W = (TIMERS > 1) ? $clog2(TIMERS) : 1,
  localparam int CNT_W = $clog2(TIMERS + 1)
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_valid,
  output logic                    in_stall,
  input  wire in_item_t           in_data,
  output logic                    out_valid,
  input  wire logic               out_stall,
  output out_item_t               out_data,
  input  wire cfg_t               cfg,
  output logic                    ram_we,
  output logic      [IDX_W-1:0]   ram_waddr,
  output logic      [COUNT_W-1:0] ram_wdata,
  output logic      [IDX_W-1:0]   ram_raddr,
  input  wire logic [COUNT_W-1:0] ram_rdata
);

  state_t              state_r, state_nxt;
  logic [CNT_W-1:0]    rd_cnt_r, rd_cnt_nxt;
  logic                proc_vld_r, proc_vld_nxt;
  logic [IDX_W-1:0]    proc_idx_r, proc_idx_nxt;
  logic [TIMERS-1:0]   written_r, written_nxt;
  logic [MASK_W-1:0]   pend_r, pend_nxt;
  logic                tick_seen_r, tick_seen_nxt;
  logic [MASK_W-1:0]   fire_r, fire_nxt;
  logic [MASK_W-1:0]   run_r, run_nxt;
  logic [MS_W-1:0]     ms_r, ms_nxt;
  logic                out_valid_r, out_valid_nxt;
  out_item_t           out_data_r, out_data_nxt;

  logic                accept;
  logic                walk_st;
  logic                done_st;
  logic                issue_rd;
  logic                walk_last;
  logic                load_out;
  logic [COUNT_W-1:0]  count_cur;
  logic [COUNT_W:0]    sum;
  logic [COUNT_W-1:0]  count_sat;
  logic                expired;
  logic                timer_en;

  // State machine outputs.
  always_comb begin
    in_stall = 1'b1;
    walk_st  = 1'b0;
    done_st  = 1'b0;
    unique case (state_r)
      ST_IDLE: in_stall = 1'b0;
      ST_WALK: walk_st  = 1'b1;
      ST_DONE: done_st  = 1'b1;
      default: in_stall = 1'b1;
    endcase
  end

  assign accept    = in_valid && !in_stall;
  assign issue_rd  = walk_st && (rd_cnt_r < CNT_W'(TIMERS));
  assign walk_last = proc_vld_r && (proc_idx_r == IDX_W'(TIMERS - 1));
  assign load_out  = done_st && (!out_valid_r || !out_stall);

  // Next state.
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (accept) begin
          state_nxt = (in_data.mode == MODE_TICK) ? ST_WALK : ST_DONE;
        end
      end
      ST_WALK: begin
        if (walk_last) begin
          state_nxt = ST_DONE;
        end
      end
      ST_DONE: begin
        if (load_out) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // Update of the entry whose count arrived from memory this cycle.
  // An entry never written since reset reads as zero.
  assign count_cur = written_r[proc_idx_r] ? ram_rdata : '0;
  assign sum       = {1'b0, count_cur} + {{(COUNT_W+1-MS_W){1'b0}}, ms_r};
  assign count_sat = sum[COUNT_W] ? {COUNT_W{1'b1}} : sum[COUNT_W-1:0];
  assign expired   = count_sat >= {{(COUNT_W-PERIOD_W){1'b0}}, cfg.period[proc_idx_r]};
  assign timer_en  = cfg.en_mask[proc_idx_r];

  assign ram_raddr = rd_cnt_r[IDX_W-1:0];
  assign ram_we    = proc_vld_r && timer_en;
  assign ram_waddr = proc_idx_r;
  assign ram_wdata = expired ? '0 : count_sat;

  // Datapath and flag updates.
  always_comb begin
    rd_cnt_nxt    = rd_cnt_r;
    proc_vld_nxt  = issue_rd;
    proc_idx_nxt  = rd_cnt_r[IDX_W-1:0];
    written_nxt   = written_r;
    pend_nxt      = pend_r;
    tick_seen_nxt = tick_seen_r;
    fire_nxt      = fire_r;
    run_nxt       = run_r;
    ms_nxt        = ms_r;
    out_valid_nxt = out_valid_r && out_stall;
    out_data_nxt  = out_data_r;

    // New transaction: a tick starts the walk, a poll settles at once.
    if (accept) begin
      fire_nxt   = '0;
      rd_cnt_nxt = '0;
      if (in_data.mode == MODE_TICK) begin
        tick_seen_nxt = 1'b1;
        ms_nxt        = in_data.elapsed_ms;
        run_nxt       = '0;
      end else if (tick_seen_r) begin
        tick_seen_nxt = 1'b0;
        run_nxt       = pend_r;
        pend_nxt      = '0;
      end else begin
        run_nxt = '0;
      end
    end

    if (issue_rd) begin
      rd_cnt_nxt = rd_cnt_r + CNT_W'(1);
    end

    // Write-back side of the walk.
    if (proc_vld_r && timer_en) begin
      written_nxt[proc_idx_r] = 1'b1;
      if (expired) begin
        if (cfg.irq_mask[proc_idx_r]) begin
          fire_nxt[proc_idx_r] = 1'b1;
        end else begin
          pend_nxt[proc_idx_r] = 1'b1;
        end
      end
    end

    // Result register.
    if (load_out) begin
      out_valid_nxt          = 1'b1;
      out_data_nxt.fire_mask = fire_r;
      out_data_nxt.run_mask  = run_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      rd_cnt_r    <= '0;
      proc_vld_r  <= 1'b0;
      written_r   <= '0;
      pend_r      <= '0;
      tick_seen_r <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      rd_cnt_r    <= rd_cnt_nxt;
      proc_vld_r  <= proc_vld_nxt;
      written_r   <= written_nxt;
      pend_r      <= pend_nxt;
      tick_seen_r <= tick_seen_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    proc_idx_r <= proc_idx_nxt;
    fire_r     <= fire_nxt;
    run_r      <= run_nxt;
    ms_r       <= ms_nxt;
    out_data_r <= out_data_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

`default_nettype wire

// ----- hw/rtl/periodic_timer_bank.sv -----
// Bank of periodic millisecond timers with deferred run flags.
// Input channel (in_valid, in_stall, in_data): a tick transaction carries the
// milliseconds elapsed and advances every enabled timer; a poll transaction
// hands over the pending flags of normal-mode timers if a tick has come since
// the previous poll. Every input transaction yields exactly one result on the
// output channel (out_valid, out_stall, out_data) holding fire_mask and
// run_mask.
// The timer counts live in a single-port-read memory and are walked one entry
// a cycle: a tick reads each count, updates it as it returns and then loads
// the result; a poll goes straight to the result load. The block is idle again
// as the result is loaded into the output register, ready for the next input.
// The output register holds a finished result while the receiver stalls; the
// block then waits to load the next result but its state is unaffected.
// The user must write registers over the APB-style port only while the block
// is idle; the block itself does not enforce it. Reset clears config, control
// state and flags at once (counts read as zero until written); no clearing pass.
`default_nettype none

module periodic_timer_bank
  import ptb_pkg::*;
#(
  parameter int TIMERS = 4
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_valid,
  output logic                   in_stall,
  input  wire in_item_t          in_data,
  output logic                   out_valid,
  input  wire logic              out_stall,
  output out_item_t              out_data,
  input  wire logic              psel,
  input  wire logic              penable,
  input  wire logic              pwrite,
  input  wire logic [ADDR_W-1:0] paddr,
  input  wire logic [DATA_W-1:0] pwdata,
  output logic      [DATA_W-1:0] prdata,
  output logic                   pready
);

  localparam int IDX_W = (TIMERS > 1) ? $clog2(TIMERS) : 1;

  cfg_t               cfg;
  logic               ram_we;
  logic [IDX_W-1:0]   ram_waddr;
  logic [COUNT_W-1:0] ram_wdata;
  logic [IDX_W-1:0]   ram_raddr;
  logic [COUNT_W-1:0] ram_rdata;

  // Configuration registers.
  ptb_cfg u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  // Timer count store.
  ptb_ram #(
    .WIDTH (COUNT_W),
    .DEPTH (TIMERS)
  ) u_count_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // Read-modify-write sequencer.
  ptb_seq #(
    .TIMERS (TIMERS)
  ) u_seq (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg       (cfg),
    .ram_we    (ram_we),
    .ram_waddr (ram_waddr),
    .ram_wdata (ram_wdata),
    .ram_raddr (ram_raddr),
    .ram_rdata (ram_rdata)
  );

  // A tick never hands over run flags and a poll never fires.
  a_masks_exclusive: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_data.fire_mask == '0 || out_data.run_mask == '0))
    else $error("fire_mask and run_mask both set in one result");

  // One transaction at a time: the input stalls right after an acceptance.
  a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall) |=> in_stall)
    else $error("input accepted while a transaction is in progress");

  // Slots beyond the configured timer count never report.
  a_no_phantom_timer: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (((out_data.fire_mask | out_data.run_mask) >> TIMERS) == '0))
    else $error("result reports a timer beyond the configured count");

endmodule

`default_nettype wire
